/* hdl/svx_pkg.sv */
// ----------------------------------------------------------------------------
// svx_pkg: shared types and constants of the stack VM execute unit
// Opcodes, error codes, register indices and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package svx_pkg;

   localparam int NUM_REGS  = 16;
   localparam int MEM_WORDS = 4096;
   localparam int WORD_W    = 64;
   localparam int HALF_W    = WORD_W / 2;
   localparam int SH_W      = $clog2(WORD_W);
   localparam int REG_AW    = $clog2(NUM_REGS);
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [4:0]        opcode_type;
   typedef logic [2:0]        err_type;
   typedef logic [3:0]        mode_type;
   typedef logic [REG_AW-1:0] reg_idx_type;
   typedef logic [MEM_AW-1:0] mem_addr_type;

   localparam opcode_type OP_NOP  = 5'd0;
   localparam opcode_type OP_HALT = 5'd1;
   localparam opcode_type OP_PUSH = 5'd2;
   localparam opcode_type OP_POP  = 5'd3;
   localparam opcode_type OP_ADD  = 5'd4;
   localparam opcode_type OP_SUB  = 5'd5;
   localparam opcode_type OP_MUL  = 5'd6;
   localparam opcode_type OP_DIV  = 5'd7;
   localparam opcode_type OP_SHL  = 5'd8;
   localparam opcode_type OP_SHR  = 5'd9;
   localparam opcode_type OP_MOD  = 5'd10;
   localparam opcode_type OP_NOT  = 5'd11;
   localparam opcode_type OP_INC  = 5'd12;
   localparam opcode_type OP_DEC  = 5'd13;
   localparam opcode_type OP_CMP  = 5'd14;
   localparam opcode_type OP_MOV  = 5'd15;
   localparam opcode_type OP_CALL = 5'd16;
   localparam opcode_type OP_RET  = 5'd17;
   localparam opcode_type OP_JMP  = 5'd18;
   localparam opcode_type OP_JEQ  = 5'd19;
   localparam opcode_type OP_JNE  = 5'd20;
   localparam opcode_type OP_JNZ  = 5'd21;

   localparam err_type ERR_NONE      = 3'd0;
   localparam err_type ERR_OVERFLOW  = 3'd1;
   localparam err_type ERR_UNDERFLOW = 3'd2;
   localparam err_type ERR_LIT_DEST  = 3'd3;
   localparam err_type ERR_BAD_ADDR  = 3'd4;
   localparam err_type ERR_DIV_ZERO  = 3'd5;
   localparam err_type ERR_NO_MODE   = 3'd6;

   localparam reg_idx_type R_SP  = reg_idx_type'(0);
   localparam reg_idx_type R_SBP = reg_idx_type'(1);
   localparam reg_idx_type R_IP  = reg_idx_type'(2);
   localparam reg_idx_type R_RMD = reg_idx_type'(3);

   localparam int M_LIT = 0;
   localparam int M_REG = 1;
   localparam int M_MEM = 2;
   localparam int M_IND = 3;

   typedef enum logic [1:0] {SEL_A, SEL_B, SEL_C} sel_type;

   typedef enum logic [4:0] {
      DP_NONE, DP_LOAD, DP_GET_LIT, DP_GET_REG, DP_RD_DIRECT, DP_RD_INDIRECT,
      DP_GET_RDATA, DP_MD_START, DP_ALU, DP_ST_REG, DP_ST_MEM_DIRECT,
      DP_ST_MEM_WHERE, DP_PUSH, DP_POP_RD, DP_POP_TAKE, DP_SET_IP_A,
      DP_COMMIT, DP_FAIL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      sel_type   sel;
      err_type   err;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       run;
      mode_type   mode;
      logic       opnd_reg_ok;
      logic       opnd_mem_ok;
      logic       val_mem_ok;
      logic       push_ovf;
      logic       push_addr_ok;
      logic       pop_unf;
      logic       pop_addr_ok;
      logic       divisor_zero;
      logic       take_branch;
      logic       md_busy;
      logic       clear_done;
      logic       out_free;
   } dp_status_type;

endpackage

/* hdl/svx_muldiv.sv */
// ----------------------------------------------------------------------------
// svx_muldiv: shared multiply and divide unit
// Multiply by three 32x32 partial products; restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module svx_muldiv
   import svx_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     is_div,
   input  word_type op_b,
   input  word_type op_c,
   output logic     busy,
   output word_type md_q,
   output word_type md_r
);

   logic               busy_ff, busy_in;
   logic               is_div_ff;
   logic [SH_W-1:0]    step_ff;
   word_type           q_ff, d_ff, r_ff, prod_ff;
   logic [HALF_W-1:0]  mul_x, mul_y;
   word_type           mul_p;
   logic [WORD_W:0]    trial, diff;
   logic               ge;

   assign trial = {r_ff, q_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = trial >= {1'b0, d_ff};

   always_comb begin
      case (step_ff[1:0])
         2'd0:    begin mul_x = q_ff[HALF_W-1:0];      mul_y = d_ff[HALF_W-1:0];      end
         2'd1:    begin mul_x = q_ff[HALF_W-1:0];      mul_y = d_ff[WORD_W-1:HALF_W]; end
         default: begin mul_x = q_ff[WORD_W-1:HALF_W]; mul_y = d_ff[HALF_W-1:0];      end
      endcase
   end

   assign mul_p = word_type'(mul_x) * word_type'(mul_y);

   always_comb begin
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (is_div_ff && step_ff == SH_W'(WORD_W - 1)) busy_in = 1'b0;
         if (!is_div_ff && step_ff == SH_W'(3)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         is_div_ff <= is_div;
         q_ff      <= op_b;
         d_ff      <= op_c;
         r_ff      <= '0;
         step_ff   <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + SH_W'(1);
         if (is_div_ff) begin
            r_ff <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            q_ff <= {q_ff[WORD_W-2:0], ge};
         end else begin
            prod_ff <= mul_p;
            case (step_ff[1:0])
               2'd0:    r_ff <= r_ff;
               2'd1:    r_ff <= prod_ff;
               default: r_ff <= r_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            endcase
         end
      end
   end

   assign busy = busy_ff;
   assign md_q = q_ff;
   assign md_r = r_ff;

endmodule

/* hdl/svx_dp.sv */
// ----------------------------------------------------------------------------
// svx_dp: datapath of the stack VM execute unit
// Register file, data memory, working copies, ALU and result register.
// ----------------------------------------------------------------------------
module svx_dp
   import svx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  opcode_type    req_opcode,
   input  word_type      req_operand_a,
   input  word_type      req_operand_b,
   input  word_type      req_operand_c,
   input  mode_type      req_mode_a,
   input  mode_type      req_mode_b,
   input  mode_type      req_mode_c,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_running,
   output err_type       rsp_error_code,
   output word_type      rsp_next_ip,
   output word_type      rsp_written_value
);

   word_type     regs_ff [NUM_REGS];
   word_type     mem_array [MEM_WORDS];
   word_type     rdata_ff;
   logic         run_ff;
   logic [MEM_AW:0] clr_cnt_ff;

   opcode_type   opcode_ff;
   word_type     opnd_ff [3];
   mode_type     mode_ff [3];
   word_type     op_ff [3];
   word_type     res_ff, written_ff, sp_ff, ip_ff, rmd_ff;
   logic         pend_reg_ff, pend_mem_ff;
   reg_idx_type  pend_reg_idx_ff;
   mem_addr_type pend_mem_addr_ff;
   word_type     pend_mem_val_ff;

   logic         rsp_valid_ff, rsp_running_ff;
   err_type      rsp_err_ff;
   word_type     rsp_ip_ff, rsp_written_ff;

   logic [1:0]   sel_idx;
   word_type     cur_opnd, cur_val, reg_rd_val, alu_res, sbp, sp_inc, push_addr, pop_addr;
   word_type     push_val;
   reg_idx_type  cur_idx;
   mem_addr_type rd_addr, wr_addr;
   word_type     wr_data;
   logic         wr_en, clear_done, md_busy;
   word_type     md_q, md_r;

   always_comb begin
      unique case (cmd.sel)
         SEL_B:   sel_idx = 2'd1;
         SEL_C:   sel_idx = 2'd2;
         default: sel_idx = 2'd0;
      endcase
   end

   assign cur_opnd = opnd_ff[sel_idx];
   assign cur_val  = op_ff[sel_idx];
   assign cur_idx  = cur_opnd[REG_AW-1:0];

   // working view of the register file: live copies of SP, IP, remainder
   always_comb begin
      if (cur_idx == R_SP)       reg_rd_val = sp_ff;
      else if (cur_idx == R_IP)  reg_rd_val = ip_ff;
      else if (cur_idx == R_RMD) reg_rd_val = rmd_ff;
      else                       reg_rd_val = regs_ff[cur_idx];
   end

   assign sbp       = regs_ff[R_SBP];
   assign sp_inc    = sp_ff + word_type'(1);
   assign push_addr = sbp - sp_inc;
   assign pop_addr  = sbp - sp_ff;
   assign push_val  = (opcode_ff == OP_CALL) ? ip_ff : op_ff[0];
   assign clear_done = clr_cnt_ff == (MEM_AW+1)'(MEM_WORDS);

   always_comb begin
      unique case (opcode_ff)
         OP_ADD:  alu_res = op_ff[1] + op_ff[2];
         OP_SUB:  alu_res = op_ff[1] - op_ff[2];
         OP_MUL:  alu_res = md_r;
         OP_DIV:  alu_res = md_q;
         OP_MOD:  alu_res = md_r;
         OP_SHL:  alu_res = (op_ff[2] >= word_type'(WORD_W)) ? '0 : op_ff[1] << op_ff[2][SH_W-1:0];
         OP_SHR:  alu_res = (op_ff[2] >= word_type'(WORD_W)) ? '0 : op_ff[1] >> op_ff[2][SH_W-1:0];
         OP_CMP:  alu_res = (op_ff[2] < op_ff[1]) ? '1 :
                            ((op_ff[2] > op_ff[1]) ? word_type'(1) : '0);
         OP_NOT:  alu_res = ~op_ff[0];
         OP_INC:  alu_res = op_ff[0] + word_type'(1);
         OP_DEC:  alu_res = op_ff[0] - word_type'(1);
         OP_MOV:  alu_res = op_ff[1];
         default: alu_res = '0;
      endcase
   end

   always_comb begin
      status.opcode       = opcode_ff;
      status.run          = run_ff;
      status.mode         = mode_ff[sel_idx];
      status.opnd_reg_ok  = cur_opnd < word_type'(NUM_REGS);
      status.opnd_mem_ok  = cur_opnd < word_type'(MEM_WORDS);
      status.val_mem_ok   = cur_val < word_type'(MEM_WORDS);
      status.push_ovf     = sp_ff >= sbp;
      status.push_addr_ok = push_addr < word_type'(MEM_WORDS);
      status.pop_unf      = sp_ff == '0;
      status.pop_addr_ok  = pop_addr < word_type'(MEM_WORDS);
      status.divisor_zero = op_ff[2] == '0;
      case (opcode_ff)
         OP_JMP:  status.take_branch = 1'b1;
         OP_JEQ:  status.take_branch = op_ff[1] == op_ff[2];
         OP_JNE:  status.take_branch = op_ff[1] != op_ff[2];
         OP_JNZ:  status.take_branch = op_ff[1] != '0;
         default: status.take_branch = 1'b0;
      endcase
      status.md_busy      = md_busy;
      status.clear_done   = clear_done;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   svx_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.op == DP_MD_START),
      .is_div (opcode_ff != OP_MUL),
      .op_b   (op_ff[1]),
      .op_c   (op_ff[2]),
      .busy   (md_busy),
      .md_q   (md_q),
      .md_r   (md_r)
   );

   // data memory: one read, one write port
   always_comb begin
      case (cmd.op)
         DP_RD_INDIRECT: rd_addr = cur_val[MEM_AW-1:0];
         DP_POP_RD:      rd_addr = pop_addr[MEM_AW-1:0];
         default:        rd_addr = cur_opnd[MEM_AW-1:0];
      endcase
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff[MEM_AW-1:0];
      wr_data = '0;
      if (!clear_done) begin
         wr_en = 1'b1;
      end else if (cmd.op == DP_COMMIT && pend_mem_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_mem_addr_ff;
         wr_data = pend_mem_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_array[wr_addr] <= wr_data;
      rdata_ff <= mem_array[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (!clear_done) begin
         clr_cnt_ff <= clr_cnt_ff + (MEM_AW+1)'(1);
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
         run_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.op == DP_COMMIT) begin
            if (pend_reg_ff) regs_ff[pend_reg_idx_ff] <= res_ff;
            regs_ff[R_SP]  <= sp_ff;
            regs_ff[R_IP]  <= ip_ff;
            regs_ff[R_RMD] <= (opcode_ff == OP_DIV) ? md_r : rmd_ff;
            run_ff         <= opcode_ff != OP_HALT;
            rsp_valid_ff   <= 1'b1;
         end else if (cmd.op == DP_FAIL) begin
            run_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_COMMIT) begin
         rsp_running_ff <= opcode_ff != OP_HALT;
         rsp_err_ff     <= ERR_NONE;
         rsp_ip_ff      <= ip_ff;
         rsp_written_ff <= written_ff;
      end else if (cmd.op == DP_FAIL) begin
         rsp_running_ff <= 1'b0;
         rsp_err_ff     <= cmd.err;
         rsp_ip_ff      <= regs_ff[R_IP];
         rsp_written_ff <= '0;
      end
   end

   // working registers of the instruction in flight
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            opcode_ff   <= req_opcode;
            opnd_ff[0]  <= req_operand_a;
            opnd_ff[1]  <= req_operand_b;
            opnd_ff[2]  <= req_operand_c;
            mode_ff[0]  <= req_mode_a;
            mode_ff[1]  <= req_mode_b;
            mode_ff[2]  <= req_mode_c;
            sp_ff       <= regs_ff[R_SP];
            ip_ff       <= regs_ff[R_IP] + word_type'(1);
            rmd_ff      <= regs_ff[R_RMD];
            written_ff  <= '0;
            pend_reg_ff <= 1'b0;
            pend_mem_ff <= 1'b0;
         end
         DP_GET_LIT:   op_ff[sel_idx] <= cur_opnd;
         DP_GET_REG:   op_ff[sel_idx] <= reg_rd_val;
         DP_GET_RDATA: op_ff[sel_idx] <= rdata_ff;
         DP_ALU:       res_ff <= alu_res;
         DP_ST_REG: begin
            written_ff <= res_ff;
            if (cur_idx == R_SP)       sp_ff  <= res_ff;
            else if (cur_idx == R_IP)  ip_ff  <= res_ff;
            else if (cur_idx == R_RMD) rmd_ff <= res_ff;
            else begin
               pend_reg_ff     <= 1'b1;
               pend_reg_idx_ff <= cur_idx;
            end
         end
         DP_ST_MEM_DIRECT: begin
            written_ff       <= res_ff;
            pend_mem_ff      <= 1'b1;
            pend_mem_addr_ff <= cur_opnd[MEM_AW-1:0];
            pend_mem_val_ff  <= res_ff;
         end
         DP_ST_MEM_WHERE: begin
            written_ff       <= res_ff;
            pend_mem_ff      <= 1'b1;
            pend_mem_addr_ff <= cur_val[MEM_AW-1:0];
            pend_mem_val_ff  <= res_ff;
         end
         DP_PUSH: begin
            sp_ff            <= sp_inc;
            written_ff       <= push_val;
            pend_mem_ff      <= 1'b1;
            pend_mem_addr_ff <= push_addr[MEM_AW-1:0];
            pend_mem_val_ff  <= push_val;
            if (opcode_ff == OP_CALL) ip_ff <= op_ff[0];
         end
         DP_POP_TAKE: begin
            res_ff <= rdata_ff;
            sp_ff  <= sp_ff - word_type'(1);
            if (opcode_ff == OP_RET) ip_ff <= rdata_ff;
         end
         DP_SET_IP_A: ip_ff <= op_ff[0];
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running       = rsp_running_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_next_ip       = rsp_ip_ff;
   assign rsp_written_value = rsp_written_ff;

endmodule

/* hdl/svx_ctrl.sv */
// ----------------------------------------------------------------------------
// svx_ctrl: instruction sequencer of the stack VM execute unit
// Walks fetch, compute, store, stack and branch steps and issues datapath commands.
// ----------------------------------------------------------------------------
module svx_ctrl
   import svx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_FETCH, S_FETCH_RDATA, S_IND_CHECK,
      S_IND_RDATA, S_MD_START, S_MD_WAIT, S_ALU, S_STORE, S_ST_RDATA,
      S_ST_WHERE, S_PUSH, S_POP, S_POP_DATA, S_BRANCH, S_FINISH
   } state_type;

   state_type state_ff, state_in, nx_state;
   sel_type   sel_ff, sel_in, nx_sel;
   err_type   err_ff, err_in;
   logic      fail_ff, fail_in;

   // step that follows a completed operand fetch
   always_comb begin
      nx_state = S_FINISH;
      nx_sel   = SEL_A;
      unique case (sel_ff)
         SEL_A: begin
            case (status.opcode) inside
               OP_PUSH, OP_CALL:         nx_state = S_PUSH;
               OP_NOT, OP_INC, OP_DEC:   nx_state = S_ALU;
               OP_JMP:                   nx_state = S_BRANCH;
               OP_JEQ, OP_JNE, OP_JNZ: begin
                  nx_state = S_FETCH;
                  nx_sel   = SEL_B;
               end
               default:                  nx_state = S_FINISH;
            endcase
         end
         SEL_B: begin
            case (status.opcode) inside
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHL, OP_SHR, OP_MOD, OP_CMP,
               OP_JEQ, OP_JNE: begin
                  nx_state = S_FETCH;
                  nx_sel   = SEL_C;
               end
               OP_MOV:  nx_state = S_ALU;
               OP_JNZ:  nx_state = S_BRANCH;
               default: nx_state = S_FINISH;
            endcase
         end
         default: begin
            case (status.opcode) inside
               OP_MUL, OP_DIV, OP_MOD:                 nx_state = S_MD_START;
               OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_CMP: nx_state = S_ALU;
               OP_JEQ, OP_JNE:                         nx_state = S_BRANCH;
               default:                                nx_state = S_FINISH;
            endcase
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      err_in    = err_ff;
      fail_in   = fail_ff;
      req_stall = 1'b1;
      cmd.op    = DP_NONE;
      cmd.sel   = sel_ff;
      cmd.err   = err_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               err_in   = ERR_NONE;
               fail_in  = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!status.run) begin
               fail_in  = 1'b1;
               state_in = S_FINISH;
            end else begin
               case (status.opcode) inside
                  OP_PUSH, OP_NOT, OP_INC, OP_DEC, OP_CALL, OP_JMP, OP_JEQ,
                  OP_JNE, OP_JNZ: begin
                     sel_in   = SEL_A;
                     state_in = S_FETCH;
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHL, OP_SHR, OP_MOD,
                  OP_CMP, OP_MOV: begin
                     sel_in   = SEL_B;
                     state_in = S_FETCH;
                  end
                  OP_POP, OP_RET: state_in = S_POP;
                  default:        state_in = S_FINISH;
               endcase
            end
         end
         S_FETCH: begin
            if (status.mode[M_LIT] || (!status.mode[M_MEM] && status.mode[M_REG])) begin
               if (!status.mode[M_LIT] && !status.opnd_reg_ok) begin
                  fail_in  = 1'b1;
                  err_in   = ERR_BAD_ADDR;
                  state_in = S_FINISH;
               end else begin
                  cmd.op = status.mode[M_LIT] ? DP_GET_LIT : DP_GET_REG;
                  if (status.mode[M_IND]) begin
                     state_in = S_IND_CHECK;
                  end else begin
                     state_in = nx_state;
                     sel_in   = nx_sel;
                  end
               end
            end else if (status.mode[M_MEM]) begin
               if (!status.opnd_mem_ok) begin
                  fail_in  = 1'b1;
                  err_in   = ERR_BAD_ADDR;
                  state_in = S_FINISH;
               end else begin
                  cmd.op   = DP_RD_DIRECT;
                  state_in = S_FETCH_RDATA;
               end
            end else begin
               fail_in  = 1'b1;
               err_in   = ERR_NO_MODE;
               state_in = S_FINISH;
            end
         end
         S_FETCH_RDATA: begin
            cmd.op = DP_GET_RDATA;
            if (status.mode[M_IND]) begin
               state_in = S_IND_CHECK;
            end else begin
               state_in = nx_state;
               sel_in   = nx_sel;
            end
         end
         S_IND_CHECK: begin
            if (!status.val_mem_ok) begin
               fail_in  = 1'b1;
               err_in   = ERR_BAD_ADDR;
               state_in = S_FINISH;
            end else begin
               cmd.op   = DP_RD_INDIRECT;
               state_in = S_IND_RDATA;
            end
         end
         S_IND_RDATA: begin
            cmd.op   = DP_GET_RDATA;
            state_in = nx_state;
            sel_in   = nx_sel;
         end
         S_MD_START: begin
            if (status.opcode != OP_MUL && status.divisor_zero) begin
               fail_in  = 1'b1;
               err_in   = ERR_DIV_ZERO;
               state_in = S_FINISH;
            end else begin
               cmd.op   = DP_MD_START;
               state_in = S_MD_WAIT;
            end
         end
         S_MD_WAIT: begin
            if (!status.md_busy) begin
               sel_in   = SEL_A;
               state_in = S_ALU;
            end
         end
         S_ALU: begin
            cmd.op   = DP_ALU;
            sel_in   = SEL_A;
            state_in = S_STORE;
         end
         S_STORE: begin
            state_in = S_FINISH;
            if (status.mode[M_LIT]) begin
               fail_in = 1'b1;
               err_in  = ERR_LIT_DEST;
            end else if (status.mode[M_REG]) begin
               if (!status.opnd_reg_ok) begin
                  fail_in = 1'b1;
                  err_in  = ERR_BAD_ADDR;
               end else if (status.mode[M_IND]) begin
                  cmd.op   = DP_GET_REG;
                  state_in = S_ST_WHERE;
               end else begin
                  cmd.op = DP_ST_REG;
               end
            end else if (status.mode[M_MEM]) begin
               if (!status.opnd_mem_ok) begin
                  fail_in = 1'b1;
                  err_in  = ERR_BAD_ADDR;
               end else if (status.mode[M_IND]) begin
                  cmd.op   = DP_RD_DIRECT;
                  state_in = S_ST_RDATA;
               end else begin
                  cmd.op = DP_ST_MEM_DIRECT;
               end
            end else begin
               fail_in = 1'b1;
               err_in  = ERR_NO_MODE;
            end
         end
         S_ST_RDATA: begin
            cmd.op   = DP_GET_RDATA;
            state_in = S_ST_WHERE;
         end
         S_ST_WHERE: begin
            state_in = S_FINISH;
            if (!status.val_mem_ok) begin
               fail_in = 1'b1;
               err_in  = ERR_BAD_ADDR;
            end else begin
               cmd.op = DP_ST_MEM_WHERE;
            end
         end
         S_PUSH: begin
            state_in = S_FINISH;
            if (status.push_ovf) begin
               fail_in = 1'b1;
               err_in  = ERR_OVERFLOW;
            end else if (!status.push_addr_ok) begin
               fail_in = 1'b1;
               err_in  = ERR_BAD_ADDR;
            end else begin
               cmd.op = DP_PUSH;
            end
         end
         S_POP: begin
            if (status.pop_unf) begin
               fail_in  = 1'b1;
               err_in   = ERR_UNDERFLOW;
               state_in = S_FINISH;
            end else if (!status.pop_addr_ok) begin
               fail_in  = 1'b1;
               err_in   = ERR_BAD_ADDR;
               state_in = S_FINISH;
            end else begin
               cmd.op   = DP_POP_RD;
               state_in = S_POP_DATA;
            end
         end
         S_POP_DATA: begin
            cmd.op = DP_POP_TAKE;
            sel_in = SEL_A;
            state_in = (status.opcode == OP_POP) ? S_STORE : S_FINISH;
         end
         S_BRANCH: begin
            if (status.take_branch) cmd.op = DP_SET_IP_A;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.op   = fail_ff ? DP_FAIL : DP_COMMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sel_ff   <= SEL_A;
         err_ff   <= ERR_NONE;
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         err_ff   <= err_in;
         fail_ff  <= fail_in;
      end
   end

endmodule

/* hdl/stack_vm_execute_unit.sv */
// ----------------------------------------------------------------------------
// stack_vm_execute_unit: executes decoded stack VM instructions
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one decoded instruction (opcode, three operands, three
//    mode nibbles); a transfer happens when req_valid is high and req_stall
//    low. rsp_* returns one result per instruction: run flag, error code,
//    next instruction pointer and the value written.
//  - The sequencer walks each instruction one step a cycle, except while it
//    waits on the multiply and divide unit or the result receiver; each
//    memory operand adds a read step, indirection a check and a second read.
//    div and mod run in the one-bit-per-cycle divider, mul in partial products.
//  - One instruction is in flight at a time; the next is taken in the cycle
//    after the previous commits, even while that result still waits
//    uncollected.
//  - Reset: the register file clears at once, the run flag sets and the
//    4096-word data memory is cleared by a sweep, one word a cycle;
//    req_stall stays high until the cycle after the sweep ends.
//  - When the receiver stalls, hold the result on rsp_* unchanged; the
//    sequencer waits before committing the next instruction.
//  - After halt or any error the machine stops: later instructions are
//    ignored and answered with running low and error code zero.
// ----------------------------------------------------------------------------
module stack_vm_execute_unit
   import svx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  opcode_type req_opcode,
   input  word_type   req_operand_a,
   input  word_type   req_operand_b,
   input  word_type   req_operand_c,
   input  mode_type   req_mode_a,
   input  mode_type   req_mode_b,
   input  mode_type   req_mode_c,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_running,
   output err_type    rsp_error_code,
   output word_type   rsp_next_ip,
   output word_type   rsp_written_value
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: issue one datapath step a cycle unless waiting on muldiv or the output
   svx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: state, memory, arithmetic and the output register
   svx_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_operand_c     (req_operand_c),
      .req_mode_a        (req_mode_a),
      .req_mode_b        (req_mode_b),
      .req_mode_c        (req_mode_c),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_running       (rsp_running),
      .rsp_error_code    (rsp_error_code),
      .rsp_next_ip       (rsp_next_ip),
      .rsp_written_value (rsp_written_value)
   );

endmodule

/* hdl/svx_checker.sv */
// ----------------------------------------------------------------------------
// svx_checker: port-level checks of the stack VM execute unit
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module svx_checker
   import svx_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_stall,
   input logic     rsp_running,
   input err_type  rsp_error_code,
   input word_type rsp_next_ip,
   input word_type rsp_written_value
);

   logic stopped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && !rsp_running) begin
         stopped_ff <= 1'b1;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_ip))
      else $error("result changed while stalled");

   a_err_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> !rsp_running && rsp_written_value == '0)
      else $error("error result shows running or a written value");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_NO_MODE)
      else $error("error code out of range");

   a_stays_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stopped_ff |-> !rsp_running && rsp_error_code == ERR_NONE
                                  && rsp_written_value == '0)
      else $error("stopped machine produced activity");

endmodule

bind stack_vm_execute_unit svx_checker u_svx_checker (.*);
